// File: design/tbfq_pkg.sv
// shared constants and codes for the two-band strict-priority queue
package tbfq_pkg;

  localparam int unsigned DEF_BAND_DEPTH = 64;
  localparam int unsigned DEF_ID_WIDTH   = 16;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned PKT_ID_W = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BYTES_W  = 18;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic [OPCODE_W-1:0] opcode_t;
  localparam opcode_t OP_ENQ  = 2'd0;
  localparam opcode_t OP_DEQ  = 2'd1;
  localparam opcode_t OP_PEEK = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_ENQUEUED   = 3'd0;
  localparam status_t ST_DROP_TOTAL = 3'd1;
  localparam status_t ST_DROP_BAND  = 3'd2;
  localparam status_t ST_DEQUEUED   = 3'd3;
  localparam status_t ST_PEEKED     = 3'd4;
  localparam status_t ST_EMPTY      = 3'd5;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TOTAL_LIMIT = 2'd0;
  localparam cfg_idx_t REG_BAND_LIMIT  = 2'd1;
  localparam cfg_idx_t REG_THRESHOLD   = 2'd2;

  localparam logic [BYTES_W-1:0] RST_TOTAL_LIMIT = 18'd10000;
  localparam logic [BYTES_W-1:0] RST_BAND_LIMIT  = 18'd75000;
  localparam logic [SIZE_W-1:0]  RST_THRESHOLD   = 32'd75000;

endpackage

// File: design/two_band_flow_size_priority_queue.sv
// two-band strict-priority descriptor queue with byte limits, top level
//
// Holds packet descriptors (handle, length) in two drop-tail FIFOs of
// BAND_DEPTH entries each. An item is an enqueue, dequeue or peek; every
// item with a valid opcode gives exactly one result item, opcode 3 is
// consumed silently. Enqueue is refused when the bytes of both bands
// together already reach total_limit_bytes; otherwise a tagged packet whose
// left_size exceeds flow_size_threshold goes to band 1, any other to band 0,
// and it is refused if it would take its band past band_limit_bytes or the
// band is full. Dequeue and peek serve band 0 first, then band 1, else
// report empty. Throughput is one item per clock unless out_ready stalls;
// each item passes the input register, decision logic and result register.
// The rate is set by the head-of-band read: each band memory is read every
// cycle at the next head pointer into a registered head word, with the
// write data forwarded when an enqueue lands on an empty band, so the
// following item always sees the current head. Configuration is taken at
// any time (cfg_ready is always high) and should be written while idle;
// writes to index 3 are ignored. Band memories need no clearing after reset.
module two_band_flow_size_priority_queue #(
  parameter int unsigned BAND_DEPTH = tbfq_pkg::DEF_BAND_DEPTH,
  parameter int unsigned ID_WIDTH   = tbfq_pkg::DEF_ID_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbfq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbfq_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input item channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tbfq_pkg::OPCODE_W-1:0]       in_opcode,
  input  logic [tbfq_pkg::PKT_ID_W-1:0]       in_packet_id,
  input  logic [tbfq_pkg::LEN_W-1:0]          in_packet_len,
  input  logic                                in_tag_present,
  input  logic [tbfq_pkg::SIZE_W-1:0]         in_left_size,
  // result item channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tbfq_pkg::STATUS_W-1:0]       out_status,
  output logic [tbfq_pkg::PKT_ID_W-1:0]       out_id,
  output logic [tbfq_pkg::LEN_W-1:0]          out_len,
  output logic                                out_band
);

  localparam int unsigned PTR_W   = (BAND_DEPTH > 1) ? $clog2(BAND_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(BAND_DEPTH + 1);
  localparam int unsigned LEN_W   = tbfq_pkg::LEN_W;
  localparam int unsigned BYTES_W = tbfq_pkg::BYTES_W;
  localparam int unsigned DESC_W  = ID_WIDTH + LEN_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BAND_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BAND_DEPTH);

  // configuration registers
  logic [BYTES_W-1:0]          total_limit_r;
  logic [BYTES_W-1:0]          band_limit_r;
  logic [tbfq_pkg::SIZE_W-1:0] threshold_r;

  // input register
  logic                          s1_valid_r;
  tbfq_pkg::opcode_t             s1_opcode_r;
  logic [tbfq_pkg::PKT_ID_W-1:0] s1_id_r;
  logic [LEN_W-1:0]              s1_len_r;
  logic                          s1_tag_r;
  logic [tbfq_pkg::SIZE_W-1:0]   s1_size_r;

  // per-band pointers, counts, byte totals and registered head words
  logic [PTR_W-1:0]   rd_r    [2];
  logic [PTR_W-1:0]   wr_r    [2];
  logic [CNT_W-1:0]   cnt_r   [2];
  logic [BYTES_W-1:0] bytes_r [2];
  logic [PTR_W-1:0]   rd_nxt    [2];
  logic [PTR_W-1:0]   wr_nxt    [2];
  logic [CNT_W-1:0]   cnt_nxt   [2];
  logic [BYTES_W-1:0] bytes_nxt [2];
  logic [DESC_W-1:0]  head_r  [2];
  logic [1:0]         wen;
  logic [DESC_W-1:0]  wdata;

  // result register
  logic                          out_valid_r;
  tbfq_pkg::status_t             out_status_r, out_status_nxt;
  logic [tbfq_pkg::PKT_ID_W-1:0] out_id_r, out_id_nxt;
  logic [LEN_W-1:0]              out_len_r, out_len_nxt;
  logic                          out_band_r, out_band_nxt;

  logic               s1_go;
  logic               enq_band;
  logic               srv_band;
  logic               srv_any;
  logic [BYTES_W:0]   total_sum;
  logic [BYTES_W:0]   band_sum;
  logic [31:0]        id_ext;
  logic [ID_WIDTH-1:0] head_id;
  logic [LEN_W-1:0]   head_len;

  // the input register moves on whenever the result register is free or being taken
  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_limit_r <= tbfq_pkg::RST_TOTAL_LIMIT;
      band_limit_r  <= tbfq_pkg::RST_BAND_LIMIT;
      threshold_r   <= tbfq_pkg::RST_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbfq_pkg::REG_TOTAL_LIMIT: total_limit_r <= cfg_data[BYTES_W-1:0];
        tbfq_pkg::REG_BAND_LIMIT:  band_limit_r  <= cfg_data[BYTES_W-1:0];
        tbfq_pkg::REG_THRESHOLD:   threshold_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode_r <= in_opcode;
      s1_id_r     <= in_packet_id;
      s1_len_r    <= in_packet_len;
      s1_tag_r    <= in_tag_present;
      s1_size_r   <= in_left_size;
    end
  end

  // band choice for an enqueue, and which band a dequeue or peek serves
  assign enq_band  = s1_tag_r && (s1_size_r > threshold_r);
  assign srv_any   = (cnt_r[0] != '0) || (cnt_r[1] != '0);
  assign srv_band  = (cnt_r[0] == '0);
  assign total_sum = {1'b0, bytes_r[0]} + {1'b0, bytes_r[1]};
  assign band_sum  = {1'b0, bytes_r[enq_band]} + (BYTES_W + 1)'(s1_len_r);
  assign id_ext    = 32'(s1_id_r);
  assign wdata     = {id_ext[ID_WIDTH-1:0], s1_len_r};
  assign head_id   = head_r[srv_band][DESC_W-1:LEN_W];
  assign head_len  = head_r[srv_band][LEN_W-1:0];

  always_comb begin
    rd_nxt         = rd_r;
    wr_nxt         = wr_r;
    cnt_nxt        = cnt_r;
    bytes_nxt      = bytes_r;
    wen            = '0;
    out_status_nxt = tbfq_pkg::ST_EMPTY;
    out_id_nxt     = '0;
    out_len_nxt    = '0;
    out_band_nxt   = 1'b0;
    if (s1_go) begin
      unique case (s1_opcode_r)
        tbfq_pkg::OP_ENQ: begin
          if (total_sum >= {1'b0, total_limit_r}) begin
            out_status_nxt = tbfq_pkg::ST_DROP_TOTAL;
          end else begin
            out_band_nxt = enq_band;
            if (band_sum > {1'b0, band_limit_r} || cnt_r[enq_band] == CNT_FULL) begin
              out_status_nxt = tbfq_pkg::ST_DROP_BAND;
            end else begin
              out_status_nxt      = tbfq_pkg::ST_ENQUEUED;
              wen[enq_band]       = 1'b1;
              cnt_nxt[enq_band]   = cnt_r[enq_band] + 1'b1;
              bytes_nxt[enq_band] = band_sum[BYTES_W-1:0];
              wr_nxt[enq_band]    = (wr_r[enq_band] == PTR_LAST) ? '0
                                    : wr_r[enq_band] + 1'b1;
            end
          end
        end
        tbfq_pkg::OP_DEQ, tbfq_pkg::OP_PEEK: begin
          if (srv_any) begin
            out_id_nxt   = tbfq_pkg::PKT_ID_W'(32'(head_id));
            out_len_nxt  = head_len;
            out_band_nxt = srv_band;
            if (s1_opcode_r == tbfq_pkg::OP_DEQ) begin
              out_status_nxt      = tbfq_pkg::ST_DEQUEUED;
              cnt_nxt[srv_band]   = cnt_r[srv_band] - 1'b1;
              bytes_nxt[srv_band] = bytes_r[srv_band] - BYTES_W'(head_len);
              rd_nxt[srv_band]    = (rd_r[srv_band] == PTR_LAST) ? '0
                                    : rd_r[srv_band] + 1'b1;
            end else begin
              out_status_nxt = tbfq_pkg::ST_PEEKED;
            end
          end
        end
        default: ;  // unused opcode: consumed, no result
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 2; b++) begin
        rd_r[b]    <= '0;
        wr_r[b]    <= '0;
        cnt_r[b]   <= '0;
        bytes_r[b] <= '0;
      end
    end else begin
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      cnt_r   <= cnt_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  // one descriptor memory per band; head word read at the next read pointer,
  // with the write forwarded when an enqueue lands on an empty band
  for (genvar g = 0; g < 2; g++) begin : g_band
    logic [DESC_W-1:0] mem_r [BAND_DEPTH];

    always_ff @(posedge clk) begin
      if (wen[g]) begin
        mem_r[wr_r[g]] <= wdata;
      end
      if (wen[g] && (wr_r[g] == rd_nxt[g])) begin
        head_r[g] <= wdata;
      end else begin
        head_r[g] <= mem_r[rd_nxt[g]];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= (s1_opcode_r == tbfq_pkg::OP_ENQ) || (s1_opcode_r == tbfq_pkg::OP_DEQ)
                     || (s1_opcode_r == tbfq_pkg::OP_PEEK);
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_status_r <= out_status_nxt;
      out_id_r     <= out_id_nxt;
      out_len_r    <= out_len_nxt;
      out_band_r   <= out_band_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_len    = out_len_r;
  assign out_band   = out_band_r;

endmodule
